// ===== rtl/core/lrf_pkg.sv =====
// shared types and constants for the lcd rectangle fill bus sequencer
package lrf_pkg;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int CRD_IN_W = 16;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [7:0] CMD_PREFIX       = 8'h00;
  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  typedef struct packed {
    logic                 reject;
    logic [COORD_W-1:0]   col_first;
    logic [COORD_W-1:0]   col_last;
    logic [COORD_W-1:0]   row_first;
    logic [COORD_W-1:0]   row_last;
    logic [COORD_W-1:0]   cols_m1;
    logic [COORD_W-1:0]   rows_m1;
  } clip_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_data;
    logic       byte_valid;
    logic       transaction_end;
    logic       fill_done;
    logic       rejected;
    logic       busy_res;
  } res_t;

endpackage

// ===== rtl/core/lrf_clip.sv =====
// rectangle reject test and clipping against the screen size
module lrf_clip #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  logic signed [lrf_pkg::CRD_IN_W-1:0] left,
  input  logic signed [lrf_pkg::CRD_IN_W-1:0] top,
  input  logic signed [lrf_pkg::CRD_IN_W-1:0] rect_width,
  input  logic signed [lrf_pkg::CRD_IN_W-1:0] rect_height,
  input  logic        [lrf_pkg::DIM_W-1:0]    screen_width,
  input  logic        [lrf_pkg::DIM_W-1:0]    screen_height,
  output lrf_pkg::clip_t                      clip
);
  import lrf_pkg::*;

  localparam int EXT_W = CRD_IN_W + 2;

  logic        [DIM_W-1:0]   sw;
  logic        [DIM_W-1:0]   sh;
  logic signed [EXT_W-1:0]   x1;
  logic signed [EXT_W-1:0]   y1;
  logic signed [EXT_W-1:0]   x2;
  logic signed [EXT_W-1:0]   y2;
  logic signed [EXT_W-1:0]   sw_s;
  logic signed [EXT_W-1:0]   sh_s;
  logic                      w_empty;
  logic                      h_empty;
  logic        [COORD_W-1:0] x1c;
  logic        [COORD_W-1:0] y1c;
  logic        [COORD_W-1:0] x2c;
  logic        [COORD_W-1:0] y2c;

  always_comb begin
    if (screen_width == '0) begin
      sw = DIM_W'(1);
    end else if (screen_width > DIM_W'(MAX_COLUMNS)) begin
      sw = DIM_W'(MAX_COLUMNS);
    end else begin
      sw = screen_width;
    end
    if (screen_height == '0) begin
      sh = DIM_W'(1);
    end else if (screen_height > DIM_W'(MAX_ROWS)) begin
      sh = DIM_W'(MAX_ROWS);
    end else begin
      sh = screen_height;
    end
  end

  assign sw_s = $signed({{(EXT_W-DIM_W){1'b0}}, sw});
  assign sh_s = $signed({{(EXT_W-DIM_W){1'b0}}, sh});
  assign x1 = EXT_W'(left);
  assign y1 = EXT_W'(top);
  assign x2 = x1 + EXT_W'(rect_width) - EXT_W'(1);
  assign y2 = y1 + EXT_W'(rect_height) - EXT_W'(1);
  assign w_empty = rect_width[CRD_IN_W-1] || (rect_width == '0);
  assign h_empty = rect_height[CRD_IN_W-1] || (rect_height == '0);

  assign x1c = left[CRD_IN_W-1] ? '0 : left[COORD_W-1:0];
  assign y1c = top[CRD_IN_W-1] ? '0 : top[COORD_W-1:0];
  assign x2c = (x2 >= sw_s) ? COORD_W'(sw - DIM_W'(1)) : x2[COORD_W-1:0];
  assign y2c = (y2 >= sh_s) ? COORD_W'(sh - DIM_W'(1)) : y2[COORD_W-1:0];

  always_comb begin
    clip.reject    = w_empty || h_empty || (x1 >= sw_s) || (y1 >= sh_s)
                     || x2[EXT_W-1] || y2[EXT_W-1];
    clip.col_first = x1c;
    clip.col_last  = x2c;
    clip.row_first = y1c;
    clip.row_last  = y2c;
    clip.cols_m1   = x2c - x1c;
    clip.rows_m1   = y2c - y1c;
  end

endmodule

// ===== rtl/core/lrf_seq.sv =====
// fill sequence state and bus byte generation
module lrf_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          op,
  input  logic [15:0]                   fill_colour,
  input  lrf_pkg::clip_t                clip,
  output lrf_pkg::res_t                 res
);
  import lrf_pkg::*;

  localparam logic [1:0] PH_COL    = 2'd0;
  localparam logic [1:0] PH_ROW    = 2'd1;
  localparam logic [1:0] PH_MEMWR  = 2'd2;
  localparam logic [1:0] PH_PIXELS = 2'd3;

  logic               running, running_next;
  logic [1:0]         phase, phase_next;
  logic [2:0]         byte_step, byte_step_next;
  logic               low_half, low_half_next;
  logic [COORD_W-1:0] col_first, col_last, row_first, row_last;
  logic [COORD_W-1:0] cols_m1;
  logic [COORD_W-1:0] cols_left, cols_left_next;
  logic [COORD_W-1:0] rows_left, rows_left_next;
  logic [15:0]        colour;
  logic               load;
  logic [COORD_W-1:0] first;
  logic [COORD_W-1:0] last;

  assign first = (phase == PH_COL) ? col_first : row_first;
  assign last  = (phase == PH_COL) ? col_last : row_last;

  always_comb begin
    running_next   = running;
    phase_next     = phase;
    byte_step_next = byte_step;
    low_half_next  = low_half;
    cols_left_next = cols_left;
    rows_left_next = rows_left;
    load           = 1'b0;
    res            = '0;
    if (op == OP_START) begin
      if (running || clip.reject) begin
        res.rejected = 1'b1;
      end else begin
        load           = 1'b1;
        running_next   = 1'b1;
        phase_next     = PH_COL;
        byte_step_next = '0;
        low_half_next  = 1'b0;
        cols_left_next = clip.cols_m1;
        rows_left_next = clip.rows_m1;
      end
    end else if (running) begin
      res.byte_valid = 1'b1;
      case (phase)
        PH_COL, PH_ROW: begin
          byte_step_next = byte_step + 3'd1;
          case (byte_step)
            3'd0: res.bus_byte = CMD_PREFIX;
            3'd1: res.bus_byte = (phase == PH_COL) ? CMD_COLUMN_SET : CMD_ROW_SET;
            3'd2: begin
              res.bus_byte = 8'(first[COORD_W-1:8]);
              res.is_data  = 1'b1;
            end
            3'd3: begin
              res.bus_byte = first[7:0];
              res.is_data  = 1'b1;
            end
            3'd4: begin
              res.bus_byte = 8'(last[COORD_W-1:8]);
              res.is_data  = 1'b1;
            end
            default: begin
              res.bus_byte        = last[7:0];
              res.is_data         = 1'b1;
              res.transaction_end = 1'b1;
              phase_next          = phase + 2'd1;
              byte_step_next      = '0;
            end
          endcase
        end
        PH_MEMWR: begin
          if (byte_step == '0) begin
            res.bus_byte   = CMD_PREFIX;
            byte_step_next = 3'd1;
          end else begin
            res.bus_byte   = CMD_MEMORY_WRITE;
            phase_next     = PH_PIXELS;
            byte_step_next = '0;
            low_half_next  = 1'b0;
          end
        end
        default: begin
          res.is_data = 1'b1;
          if (!low_half) begin
            res.bus_byte  = colour[15:8];
            low_half_next = 1'b1;
          end else begin
            res.bus_byte  = colour[7:0];
            low_half_next = 1'b0;
            if (cols_left == '0 && rows_left == '0) begin
              res.transaction_end = 1'b1;
              res.fill_done       = 1'b1;
              running_next        = 1'b0;
              phase_next          = PH_COL;
            end else if (cols_left == '0) begin
              cols_left_next = cols_m1;
              rows_left_next = rows_left - COORD_W'(1);
            end else begin
              cols_left_next = cols_left - COORD_W'(1);
            end
          end
        end
      endcase
    end
    res.busy_res = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      phase     <= PH_COL;
      byte_step <= '0;
      low_half  <= 1'b0;
      cols_left <= '0;
      rows_left <= '0;
    end else if (step) begin
      running   <= running_next;
      phase     <= phase_next;
      byte_step <= byte_step_next;
      low_half  <= low_half_next;
      cols_left <= cols_left_next;
      rows_left <= rows_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && load) begin
      col_first <= clip.col_first;
      col_last  <= clip.col_last;
      row_first <= clip.row_first;
      row_last  <= clip.row_last;
      cols_m1   <= clip.cols_m1;
      colour    <= fill_colour;
    end
  end

endmodule

// ===== rtl/core/lcd_rect_fill_bus_sequencer_top.sv =====
// top level of the lcd rectangle fill bus sequencer
// Each input beat produces exactly one output beat. A start beat (tuser 0) clips the
// rectangle to the screen and arms the sequence, or comes back with rejected set; each tick
// beat (tuser 1) then yields the next byte of the column window, row window, memory write
// command and pixel colour bytes. A beat passes through an input register and one result
// register, and one beat is taken every cycle while the output is drained; throughput is
// limited only by the downstream tready.
module lcd_rect_fill_bus_sequencer_top #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // left, top, rect_width, rect_height, fill_colour
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // bus_byte, byte_valid, fill_done, rejected, busy_res, zeros
  output logic        m_tuser,   // is_data
  output logic        m_tlast,   // transaction_end
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import lrf_pkg::*;

  logic               in_valid;
  logic               in_op;
  logic [79:0]        in_data;
  logic               out_free;
  logic               step;
  logic [DIM_W-1:0]   screen_width;
  logic [DIM_W-1:0]   screen_height;
  clip_t              clip;
  res_t               res;

  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_W'(320);
      screen_height <= DIM_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_data <= s_tdata;
    end
  end

  lrf_clip #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_clip (
    .left          ($signed(in_data[15:0])),
    .top           ($signed(in_data[31:16])),
    .rect_width    ($signed(in_data[47:32])),
    .rect_height   ($signed(in_data[63:48])),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .clip          (clip)
  );

  lrf_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .op          (in_op),
    .fill_colour (in_data[79:64]),
    .clip        (clip),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {4'b0000, res.busy_res, res.rejected, res.fill_done, res.byte_valid,
                  res.bus_byte};
      m_tuser <= res.is_data;
      m_tlast <= res.transaction_end;
    end
  end

  // end of fill closes the transaction and drops busy
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tlast && m_tdata[8] && !m_tdata[11])
    else $error("fill_done without transaction end or with busy");

  // a rejected start never strobes the bus
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> !m_tdata[8] && !m_tuser && !m_tlast)
    else $error("rejected beat carries a bus byte");

  // an empty output register always lets the input side move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with output register empty");

  // a processed beat shows up at the output on the next edge
  a_step_to_out: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("processed beat lost");

endmodule

// ===== dv/tb_lcd_rect_fill_bus_sequencer_top.sv =====
// testbench for the lcd rectangle fill bus sequencer, checked beat by beat against a local model
module tb_lcd_rect_fill_bus_sequencer_top;
  import lrf_pkg::*;

  localparam int COLS_MAX = 4096;
  localparam int ROWS_MAX = 4096;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  localparam res_t NO_BYTE   = '0;
  localparam res_t REJ_IDLE  = '{rejected: 1'b1, default: '0};
  localparam res_t ARMED     = '{busy_res: 1'b1, default: '0};
  localparam res_t REJ_BUSY  = '{rejected: 1'b1, busy_res: 1'b1, default: '0};

  typedef enum logic [2:0] {PH_COLS, PH_ROWS, PH_MEMWR, PH_PIXELS} fill_phase_t;

  typedef struct {
    logic        op;
    logic [15:0] l, t, w, h, c;
    bit          typed;
    res_t        want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // left, top, rect_width, rect_height, fill_colour
  logic        s_tuser = 1'b0; // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // bus_byte, byte_valid, fill_done, rejected, busy_res, zeros
  logic        m_tuser;        // is_data
  logic        m_tlast;        // transaction_end
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;

  // fill model state
  bit [12:0]   scr_w = 13'd320;
  bit [12:0]   scr_h = 13'd480;
  bit          fill_on = 1'b0;
  fill_phase_t ph = PH_COLS;
  int          seq_step = 0;
  logic [23:0] px_left = '0;
  bit          low_next = 1'b0;
  logic [11:0] win_c0 = '0, win_c1 = '0, win_r0 = '0, win_r1 = '0;
  logic [15:0] colour_q = '0;

  res_t        pending_bus_q[$];
  dir_row_t    dir_rows[$];
  int          beats_sent = 0;
  int          mism_cnt = 0;
  int          send_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_cnt = 0;
  int unsigned cyc = 0;

  int          idle_tab[4] = '{0, 65, 0, 22};
  int          stall_tab[4] = '{0, 0, 65, 22};
  bit [12:0]   scr_w_tab[8] = '{13'd320, 13'd4096, 13'd1, 13'd0, 13'd8191, 13'd7, 13'd4096, 13'd1};
  bit [12:0]   scr_h_tab[8] = '{13'd480, 13'd4096, 13'd1, 13'd8191, 13'd0, 13'd5, 13'd1, 13'd4096};

  lcd_rect_fill_bus_sequencer_top #(
    .MAX_COLUMNS(COLS_MAX),
    .MAX_ROWS   (ROWS_MAX)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int eff_dim(bit [12:0] v, int maxv);
    if (v == 13'd0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic res_t step_fill_model(logic op, logic [15:0] l, t, w, h, c);
    res_t        r;
    int          x1, y1, x2, y2, wi, hi, sw, sh;
    logic [11:0] win_lo, win_hi;
    r = '0;
    if (op == OP_START) begin
      x1 = int'($signed(l));
      y1 = int'($signed(t));
      wi = int'($signed(w));
      hi = int'($signed(h));
      sw = eff_dim(scr_w, COLS_MAX);
      sh = eff_dim(scr_h, ROWS_MAX);
      x2 = x1 + wi - 1;
      y2 = y1 + hi - 1;
      if (fill_on || wi <= 0 || hi <= 0 || x1 >= sw || y1 >= sh || x2 < 0 || y2 < 0) begin
        r.rejected = 1'b1;
      end else begin
        if (x1 < 0) x1 = 0;
        if (y1 < 0) y1 = 0;
        if (x2 >= sw) x2 = sw - 1;
        if (y2 >= sh) y2 = sh - 1;
        win_c0 = 12'(x1);
        win_c1 = 12'(x2);
        win_r0 = 12'(y1);
        win_r1 = 12'(y2);
        px_left = 24'((x2 - x1 + 1) * (y2 - y1 + 1) - 1);
        colour_q = c;
        fill_on = 1'b1;
        ph = PH_COLS;
        seq_step = 0;
        low_next = 1'b0;
      end
    end else if (fill_on) begin
      case (ph)
        PH_COLS, PH_ROWS: begin
          win_lo = (ph == PH_COLS) ? win_c0 : win_r0;
          win_hi = (ph == PH_COLS) ? win_c1 : win_r1;
          r.byte_valid = 1'b1;
          case (seq_step)
            0: r.bus_byte = CMD_PREFIX;
            1: r.bus_byte = (ph == PH_COLS) ? CMD_COLUMN_SET : CMD_ROW_SET;
            2: begin
              r.bus_byte = {4'h0, win_lo[11:8]};
              r.is_data = 1'b1;
            end
            3: begin
              r.bus_byte = win_lo[7:0];
              r.is_data = 1'b1;
            end
            4: begin
              r.bus_byte = {4'h0, win_hi[11:8]};
              r.is_data = 1'b1;
            end
            default: begin
              r.bus_byte = win_hi[7:0];
              r.is_data = 1'b1;
              r.transaction_end = 1'b1;
            end
          endcase
          if (r.transaction_end) begin
            ph = (ph == PH_COLS) ? PH_ROWS : PH_MEMWR;
            seq_step = 0;
          end else begin
            seq_step++;
          end
        end
        PH_MEMWR: begin
          r.byte_valid = 1'b1;
          if (seq_step == 0) begin
            r.bus_byte = CMD_PREFIX;
            seq_step = 1;
          end else begin
            r.bus_byte = CMD_MEMORY_WRITE;
            ph = PH_PIXELS;
            seq_step = 0;
            low_next = 1'b0;
          end
        end
        PH_PIXELS: begin
          r.byte_valid = 1'b1;
          r.is_data = 1'b1;
          if (!low_next) begin
            r.bus_byte = colour_q[15:8];
            low_next = 1'b1;
          end else begin
            r.bus_byte = colour_q[7:0];
            low_next = 1'b0;
            if (px_left == 24'd0) begin
              r.transaction_end = 1'b1;
              r.fill_done = 1'b1;
              fill_on = 1'b0;
              ph = PH_COLS;
            end else begin
              px_left = px_left - 24'd1;
            end
          end
        end
        default: begin
          fill_on = 1'b0;
          ph = PH_COLS;
          seq_step = 0;
        end
      endcase
    end
    r.busy_res = fill_on;
    return r;
  endfunction

  task automatic send_beat(input logic op, input logic [15:0] l, t, w, h, c,
                           input bit typed, input res_t want);
    res_t pred;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {c, h, w, t, l};
    do @(posedge clk); while (!s_tready);
    pred = step_fill_model(op, l, t, w, h, c);
    pending_bus_q.push_back(typed ? want : pred);
    beats_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_bus_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_screen(input bit [12:0] wv, hv);
    cfg_we <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= wv;
    @(posedge clk);
    scr_w = wv;
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data <= hv;
    @(posedge clk);
    scr_h = hv;
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_edge(int span);
    case ($urandom_range(0, 2))
      0: return int'($urandom_range(0, 6)) - 3;
      1: return span - 1 - int'($urandom_range(0, 3));
      default: return int'($urandom_range(0, span - 1));
    endcase
  endfunction

  task automatic run_random(input int n_beats);
    int          stop_at, sw, sh, r, n;
    logic [15:0] l, t, w, h, c;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      sw = eff_dim(scr_w, COLS_MAX);
      sh = eff_dim(scr_h, ROWS_MAX);
      l = 16'($urandom);
      t = 16'($urandom);
      w = 16'($urandom);
      h = 16'($urandom);
      c = 16'($urandom);
      r = int'($urandom_range(0, 99));
      if (r < 70) begin
        l = 16'(pick_edge(sw));
        t = 16'(pick_edge(sh));
        w = 16'($urandom_range(1, 4));
        h = 16'($urandom_range(1, 4));
        if (sw * sh <= 64 && $urandom_range(0, 3) == 0) begin
          w = 16'($urandom_range(1, 32767));
          h = 16'($urandom_range(1, 32767));
        end
        send_beat(OP_START, l, t, w, h, c, 1'b0, NO_BYTE);
        while (fill_on) begin
          send_beat(($urandom_range(0, 19) == 0) ? OP_START : OP_TICK, 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, NO_BYTE);
        end
      end else if (r < 85) begin
        // start that fails for one forced reason, other fields random
        case ($urandom_range(0, 5))
          0: w = $urandom_range(0, 1) ? 16'h0000 : {1'b1, 15'($urandom)};
          1: h = $urandom_range(0, 1) ? 16'h0000 : {1'b1, 15'($urandom)};
          2: l = 16'($urandom_range(sw, 32767));
          3: t = 16'($urandom_range(sh, 32767));
          4: begin
            n = int'($urandom_range(1, 32768));
            l = 16'(-n);
            w = 16'($urandom_range(1, n));
          end
          default: begin
            n = int'($urandom_range(1, 32768));
            t = 16'(-n);
            h = 16'($urandom_range(1, n));
          end
        endcase
        send_beat(OP_START, l, t, w, h, c, 1'b0, NO_BYTE);
      end else begin
        send_beat(OP_TICK, l, t, w, h, c, 1'b0, NO_BYTE);
      end
    end
  endtask

  // sink side with random stall and one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : rx_check
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.bus_byte = m_tdata[7:0];
      got.byte_valid = m_tdata[8];
      got.fill_done = m_tdata[9];
      got.rejected = m_tdata[10];
      got.busy_res = m_tdata[11];
      got.is_data = m_tuser;
      got.transaction_end = m_tlast;
      if (pending_bus_q.size() == 0) begin
        if (mism_cnt < 10) $display("unexpected beat: byte=%h", got.bus_byte);
        mism_cnt++;
      end else begin
        want = pending_bus_q.pop_front();
        if (got !== want) begin
          if (mism_cnt < 10) begin
            $display("mismatch want byte=%h data=%b strb=%b end=%b done=%b rej=%b busy=%b",
                     want.bus_byte, want.is_data, want.byte_valid, want.transaction_end,
                     want.fill_done, want.rejected, want.busy_res);
            $display("         got  byte=%h data=%b strb=%b end=%b done=%b rej=%b busy=%b",
                     got.bus_byte, got.is_data, got.byte_valid, got.transaction_end,
                     got.fill_done, got.rejected, got.busy_res);
          end
          mism_cnt++;
        end
      end
    end
  end

  initial begin
    dir_rows.push_back('{OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, NO_BYTE});
    dir_rows.push_back('{OP_START, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h1234, 1'b1, REJ_IDLE});
    dir_rows.push_back('{OP_START, 16'h0000, 16'h0000, 16'h0001, 16'h8000, 16'h1234, 1'b1, REJ_IDLE});
    dir_rows.push_back('{OP_START, 16'd320, 16'h0000, 16'h0001, 16'h0001, 16'h1234, 1'b1, REJ_IDLE});
    dir_rows.push_back('{OP_START, 16'h0000, 16'h7FFF, 16'h0001, 16'h0001, 16'h1234, 1'b1, REJ_IDLE});
    dir_rows.push_back('{OP_START, 16'h8000, 16'h0000, 16'h7FFF, 16'h0001, 16'h1234, 1'b1, REJ_IDLE});
    dir_rows.push_back('{OP_START, 16'hFFFF, 16'hFFFF, 16'h0002, 16'h0002, 16'hFFFF, 1'b1, ARMED});
    dir_rows.push_back('{OP_START, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0000, 1'b1, REJ_BUSY});
    for (int i = 0; i < 16; i++) begin
      dir_rows.push_back('{OP_TICK, {16{i[0]}}, {16{i[0]}}, {16{i[0]}}, {16{i[0]}}, {16{i[0]}},
                           1'b0, NO_BYTE});
    end
    dir_rows.push_back('{OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, NO_BYTE});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].op, dir_rows[i].l, dir_rows[i].t, dir_rows[i].w, dir_rows[i].h,
                dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
    end
    drain();

    for (int p = 0; p < 8; p++) begin
      write_screen(scr_w_tab[p], scr_h_tab[p]);
      send_idle_pct = idle_tab[p % 4];
      rx_stall_pct = stall_tab[p % 4];
      if (p == 0) hold_req <= 1'b1;
      run_random(241);
      drain();
    end

    repeat (8) @(posedge clk);
    if (mism_cnt == 0 && pending_bus_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== lcd_rect_fill_bus_sequencer_top.f =====
rtl/core/lrf_pkg.sv
rtl/core/lrf_clip.sv
rtl/core/lrf_seq.sv
rtl/core/lcd_rect_fill_bus_sequencer_top.sv
dv/tb_lcd_rect_fill_bus_sequencer_top.sv
